// ===== rtl/core/rgbhsv_pkg.sv =====
// Shared constants, types and stage record for the RGB to HSV converter.
package rgbhsv_pkg;
    localparam int CHANNEL_BITS = 8;
    localparam int QUOT_BITS    = (CHANNEL_BITS > 6) ? CHANNEL_BITS : 6;
    localparam int NUM_BITS     = 2 * CHANNEL_BITS + 6;
    localparam int HUE_BITS     = 9;
    localparam int FULL         = (1 << CHANNEL_BITS) - 1;

    localparam logic [HUE_BITS-1:0] HUE_RED   = HUE_BITS'(0);
    localparam logic [HUE_BITS-1:0] HUE_GREEN = HUE_BITS'(120);
    localparam logic [HUE_BITS-1:0] HUE_BLUE  = HUE_BITS'(240);
    localparam logic [HUE_BITS-1:0] HUE_WRAP  = HUE_BITS'(360);

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [NUM_BITS-1:0]     num_t;
    typedef logic [QUOT_BITS-1:0]    quot_t;
    typedef logic [HUE_BITS-1:0]     hue_t;

    typedef struct packed {
        logic  valid;
        num_t  sat_n;
        num_t  sat_d;
        num_t  hue_n;
        num_t  hue_d;
        quot_t q_sat;
        quot_t q_hue;
        hue_t  base;
        logic  neg;
        chan_t value;
    } stage_t;
endpackage

// ===== rtl/core/rgbhsv_if.sv =====
// Pixel input and HSV output channel interfaces.
interface rgbhsv_pix_if;
    logic                       valid;
    logic                       ready;
    logic [rgbhsv_pkg::CHANNEL_BITS-1:0] red;
    logic [rgbhsv_pkg::CHANNEL_BITS-1:0] green;
    logic [rgbhsv_pkg::CHANNEL_BITS-1:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_hsv_if;
    logic                                valid;
    logic                                ready;
    logic [rgbhsv_pkg::HUE_BITS-1:0]     hue;
    logic [rgbhsv_pkg::CHANNEL_BITS-1:0] saturation;
    logic [rgbhsv_pkg::CHANNEL_BITS-1:0] value;
    modport source (output valid, hue, saturation, value, input ready);
    modport sink   (input valid, hue, saturation, value, output ready);
endinterface

// ===== rtl/core/rgbhsv_front.sv =====
// Front stage: max, min, sector selection and divider operand setup.
module rgbhsv_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rgbhsv_pkg::chan_t  red,
    input  rgbhsv_pkg::chan_t  green,
    input  rgbhsv_pkg::chan_t  blue,
    output rgbhsv_pkg::stage_t stage
);
    import rgbhsv_pkg::*;

    stage_t stage_reg;
    stage_t stage_next;
    chan_t  mx;
    chan_t  mn;
    chan_t  delta;
    chan_t  op_a;
    chan_t  op_b;
    chan_t  diff;
    chan_t  hue_div;
    chan_t  sat_div;
    logic   neg;
    hue_t   base;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        delta = mx - mn;
        if (red == mx)
        begin
            op_a = green;
            op_b = blue;
            base = HUE_RED;
        end
        else if (green == mx)
        begin
            op_a = blue;
            op_b = red;
            base = HUE_GREEN;
        end
        else
        begin
            op_a = red;
            op_b = green;
            base = HUE_BLUE;
        end
        neg  = (op_a < op_b);
        diff = neg ? (op_b - op_a) : (op_a - op_b);
        if (neg && (base == HUE_RED)) base = HUE_WRAP;
        hue_div = (delta == '0) ? chan_t'(1) : delta;
        sat_div = (mx == '0) ? chan_t'(1) : mx;

        stage_next.valid = in_valid;
        stage_next.hue_n = num_t'(diff) * num_t'(60)
                         + (neg ? num_t'(delta - chan_t'(1)) : '0);
        stage_next.hue_d = num_t'(hue_div) << (QUOT_BITS - 1);
        stage_next.sat_n = num_t'(delta) * num_t'(FULL);
        stage_next.sat_d = num_t'(sat_div) << (QUOT_BITS - 1);
        stage_next.q_sat = '0;
        stage_next.q_hue = '0;
        stage_next.base  = base;
        stage_next.neg   = neg;
        stage_next.value = mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign stage = stage_reg;
endmodule

// ===== rtl/core/rgbhsv_cell.sv =====
// Divider cell: one quotient bit of both the hue and saturation divisions.
module rgbhsv_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  rgbhsv_pkg::stage_t stage_in,
    output rgbhsv_pkg::stage_t stage_out
);
    import rgbhsv_pkg::*;

    stage_t stage_reg;
    stage_t stage_next;
    logic   sat_ge;
    logic   hue_ge;

    always_comb
    begin
        stage_next = stage_in;
        sat_ge = (stage_in.sat_n >= stage_in.sat_d);
        hue_ge = (stage_in.hue_n >= stage_in.hue_d);
        if (sat_ge) stage_next.sat_n = stage_in.sat_n - stage_in.sat_d;
        if (hue_ge) stage_next.hue_n = stage_in.hue_n - stage_in.hue_d;
        stage_next.sat_d = stage_in.sat_d >> 1;
        stage_next.hue_d = stage_in.hue_d >> 1;
        stage_next.q_sat = {stage_in.q_sat[QUOT_BITS-2:0], sat_ge};
        stage_next.q_hue = {stage_in.q_hue[QUOT_BITS-2:0], hue_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;
endmodule

// ===== rtl/core/rgb_to_hsv_converter_unit.sv =====
// Top level of the RGB to HSV converter: front stage, divider cell row, output stage.
// Accepts one pixel per clock unless the output stalls, and returns hue, saturation and
// value through one front stage, one divider cell per quotient bit and one output
// register. The whole pipeline holds while a result waits at the output and is not
// taken.
module rgb_to_hsv_converter_unit (
    input logic          clk,
    input logic          rst_n,
    rgbhsv_pix_if.sink   pix,
    rgbhsv_hsv_if.source hsv
);
    import rgbhsv_pkg::*;

    stage_t chain [QUOT_BITS+1];
    logic   en;
    logic   out_valid_reg;
    hue_t   hue_reg;
    chan_t  sat_reg;
    chan_t  value_reg;
    logic [HUE_BITS:0] hue_sum;
    hue_t   hue_next;

    assign en        = !out_valid_reg || hsv.ready;
    assign pix.ready = en;

    rgbhsv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pix.valid),
        .red      (pix.red),
        .green    (pix.green),
        .blue     (pix.blue),
        .stage    (chain[0])
    );

    for (genvar i = 0; i < QUOT_BITS; i++)
    begin : g_cell
        rgbhsv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    always_comb
    begin
        if (chain[QUOT_BITS].neg)
            hue_sum = {1'b0, chain[QUOT_BITS].base}
                    - (HUE_BITS+1)'(chain[QUOT_BITS].q_hue);
        else
            hue_sum = {1'b0, chain[QUOT_BITS].base}
                    + (HUE_BITS+1)'(chain[QUOT_BITS].q_hue);
        if (hue_sum >= {1'b0, HUE_WRAP})
            hue_next = hue_t'(hue_sum - {1'b0, HUE_WRAP});
        else
            hue_next = hue_sum[HUE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain[QUOT_BITS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= chain[QUOT_BITS].q_sat[CHANNEL_BITS-1:0];
            value_reg <= chain[QUOT_BITS].value;
        end
    end

    assign hsv.valid      = out_valid_reg;
    assign hsv.hue        = hue_reg;
    assign hsv.saturation = sat_reg;
    assign hsv.value      = value_reg;
endmodule

// ===== test/rgbhsv_if.sv =====
// Testbench channels use the pixel and HSV interfaces defined with the converter RTL.

// ===== test/tb_rgb_to_hsv_converter_unit.sv =====
// Self-checking testbench for the RGB to HSV converter with directed and random pixels.
module tb_rgb_to_hsv_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhsv_pkg::*;

    typedef struct packed {
        hue_t  hue;
        chan_t sat;
        chan_t val;
    } hsv_t;

    typedef struct {
        chan_t r;
        chan_t g;
        chan_t b;
        logic  known;
        hsv_t  res;
    } pix_row_t;

    localparam int RANDOM_PIXELS = 1900;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LATENCY       = QUOT_BITS + 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    rgbhsv_pix_if pix ();
    rgbhsv_hsv_if hsv ();

    rgb_to_hsv_converter_unit dut (.clk(clk), .rst_n(rst_n), .pix(pix), .hsv(hsv));

    always #5 clk = ~clk;

    hsv_t     pending_hsv[$];
    pix_row_t directed[$];
    int       errors = 0;
    int       cycles = 0;
    int       send_idle = 0;
    int       recv_stall = 0;
    int       hold_off = 0;
    int       received = 0;
    int       sent = 0;
    bit       done_sending = 0;

    function automatic hsv_t hsv_of(chan_t r, chan_t g, chan_t b);
        int   mx, mn, d, h;
        hsv_t o;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        h = 0;
        o.sat = '0;
        if (d != 0)
        begin
            o.sat = chan_t'((FULL * d) / mx);
            if (r == mx)
                h = (g >= b) ? (60 * (g - b)) / d : 360 - (60 * (b - g) + d - 1) / d;
            else if (g == mx)
                h = (b >= r) ? 120 + (60 * (b - r)) / d : 120 - (60 * (r - b) + d - 1) / d;
            else
                h = (r >= g) ? 240 + (60 * (r - g)) / d : 240 - (60 * (g - r) + d - 1) / d;
            if (h >= 360)
                h -= 360;
        end
        o.hue = hue_t'(h);
        o.val = chan_t'(mx);
        return o;
    endfunction

    function automatic void add_row(int r, int g, int b, bit known, int h, int s, int v);
        pix_row_t row;
        row.r = chan_t'(r); row.g = chan_t'(g); row.b = chan_t'(b);
        row.known = known;
        row.res = '{hue_t'(h), chan_t'(s), chan_t'(v)};
        directed = {directed, row};
    endfunction

    function automatic void pick_pixel(output chan_t r, output chan_t g, output chan_t b);
        int m;
        m = $urandom_range(0, 9);
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
        if (m == 0)
        begin
            g = r; b = r;
        end
        else if (m == 1)
            g = r;
        else if (m == 2)
            b = g;
        else if (m == 3)
            b = r;
        else if (m == 4)
        begin
            r = chan_t'($urandom_range(0, 3)); g = chan_t'($urandom_range(0, 3));
            b = chan_t'($urandom_range(0, 3));
        end
    endfunction

    function automatic void send_pixel(chan_t r, chan_t g, chan_t b);
        pix.valid <= 1'b1;
        pix.red   <= r;
        pix.green <= g;
        pix.blue  <= b;
    endfunction

    function automatic int idle_pct(int ph);
        return (ph == 1 || ph == 3) ? 56 : ((ph == 4) ? 9 : 0);
    endfunction

    function automatic int stall_pct(int ph);
        return (ph == 2 || ph == 3) ? 56 : ((ph == 4) ? 9 : 0);
    endfunction

    int phase = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t after %0d transfers", $time, received);
            $display("tb_rgb_to_hsv_converter_unit failed");
            $finish;
        end
    end

    // receiver side: check and drive ready
    always @(posedge clk)
    begin
        hsv_t exp_v;
        if (rst_n && hsv.valid && hsv.ready)
        begin
            received <= received + 1;
            if (pending_hsv.size() == 0)
            begin
                errors <= errors + 1;
                $display("%0t: unexpected transfer hue=%0d sat=%0d val=%0d", $time,
                         hsv.hue, hsv.saturation, hsv.value);
            end
            else
            begin
                exp_v = pending_hsv.pop_front();
                if (hsv.hue !== exp_v.hue)
                    $display("%0t: hue expected %0d actual %0d", $time, exp_v.hue, hsv.hue);
                if (hsv.saturation !== exp_v.sat)
                    $display("%0t: saturation expected %0d actual %0d", $time, exp_v.sat,
                             hsv.saturation);
                if (hsv.value !== exp_v.val)
                    $display("%0t: value expected %0d actual %0d", $time, exp_v.val,
                             hsv.value);
                if (hsv.hue !== exp_v.hue || hsv.saturation !== exp_v.sat
                    || hsv.value !== exp_v.val)
                    errors <= errors + 1;
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            hsv.ready <= 1'b0;
        end
        else
            hsv.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct(phase));
    end

    task automatic drive_pixel(chan_t r, chan_t g, chan_t b);
        while ($urandom_range(0, 99) < idle_pct(phase))
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        send_pixel(r, g, b);
        do
            @(posedge clk);
        while (!pix.ready);
        pending_hsv = {pending_hsv, hsv_of(r, g, b)};
        sent++;
    endtask

    initial
    begin
        chan_t r, g, b;
        pix.valid = 1'b0;
        pix.red = '0; pix.green = '0; pix.blue = '0;
        hsv.ready = 1'b0;
        add_row(0, 0, 0, 1, 0, 0, 0);
        add_row(255, 255, 255, 1, 0, 0, 255);
        add_row(77, 77, 77, 1, 0, 0, 77);
        add_row(255, 0, 0, 1, 0, 255, 255);
        add_row(0, 255, 0, 1, 120, 255, 255);
        add_row(0, 0, 255, 1, 240, 255, 255);
        add_row(255, 255, 0, 1, 60, 255, 255);
        add_row(0, 255, 255, 1, 180, 255, 255);
        add_row(255, 0, 255, 1, 300, 255, 255);
        add_row(1, 0, 0, 1, 0, 255, 1);
        add_row(255, 254, 254, 1, 0, 1, 255);
        add_row(255, 0, 1, 0, 0, 0, 0);
        add_row(255, 1, 0, 0, 0, 0, 0);
        add_row(0, 255, 1, 0, 0, 0, 0);
        add_row(1, 255, 0, 0, 0, 0, 0);
        add_row(1, 0, 255, 0, 0, 0, 0);
        add_row(0, 1, 255, 0, 0, 0, 0);
        add_row(170, 85, 170, 0, 0, 0, 0);
        add_row(128, 128, 127, 0, 0, 0, 0);
        add_row(127, 128, 128, 0, 0, 0, 0);
        add_row(200, 100, 150, 0, 0, 0, 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            if (directed[i].known && hsv_of(directed[i].r, directed[i].g, directed[i].b)
                                     !== directed[i].res)
                $display("note: row %0d table and predictor differ", i);
            drive_pixel(directed[i].r, directed[i].g, directed[i].b);
            if (directed[i].known)
                pending_hsv[$] = directed[i].res;
        end
        for (int ph = 0; ph < 5; ph++)
        begin
            phase = ph;
            if (ph == 2)
                hold_off = 200;
            repeat (RANDOM_PIXELS / 5)
            begin
                pick_pixel(r, g, b);
                drive_pixel(r, g, b);
            end
        end
        pix.valid <= 1'b0;
        phase = 0;
        done_sending = 1;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        $display("sent %0d pixels (%0d directed), checked %0d results over five idle patterns",
                 sent, directed.size(), received);
        $display("including a %0d-cycle output hold-off that backed up the pipeline", 200);
        if (errors == 0 && pending_hsv.size() == 0)
            $display("tb_rgb_to_hsv_converter_unit passed");
        else
            $display("tb_rgb_to_hsv_converter_unit failed");
        $finish;
    end
endmodule
